FILE: sv/msps_pkg.sv
// Shared constants, types and tables for the Mode S preamble and bit slicer.
`default_nettype none
package msps_pkg;
  localparam int RingDepthDef  = 512;
  localparam int PreambleLen   = 23;
  localparam int ByteSamples   = 23;
  localparam int ScanWindow    = PreambleLen + 3 + 14 * ByteSamples + 1;
  localparam int MaxTrial      = 19;
  localparam logic [31:0] ShortDfSet = 32'h0000_0831;
  localparam logic [31:0] LongDfSet  = 32'h0037_0000;
  localparam logic [9:0] ThreshReset = 10'd58;
  localparam logic [8:0] SkipLong    = 9'd268;
  localparam logic [8:0] SkipShort   = 9'd134;
  localparam logic [0:0] CfgThreshold = 1'b0;
  localparam logic [0:0] CfgTrial     = 1'b1;

  // Slice job handed from the scan front to the slicer.
  typedef struct packed {
    logic [9:0] base;   // window base address, wide enough for depths up to 1024
  } job_t;

  // One result item.
  typedef struct packed {
    logic [7:0] data_byte;
    logic [3:0] byte_index;
    logic       long_message;
    logic       last_byte;
  } res_t;

  // Sample offset within a byte for phase ph, bit k.
  function automatic logic [4:0] bit_off(input logic [2:0] ph, input logic [2:0] k);
    logic [4:0] t [5][8];
    t[0] = '{5'd0, 5'd2, 5'd5, 5'd8, 5'd11, 5'd14, 5'd17, 5'd20};
    t[1] = '{5'd0, 5'd3, 5'd5, 5'd8, 5'd11, 5'd14, 5'd17, 5'd20};
    t[2] = '{5'd0, 5'd3, 5'd6, 5'd9, 5'd11, 5'd14, 5'd17, 5'd20};
    t[3] = '{5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd14, 5'd17, 5'd20};
    t[4] = '{5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd20};
    return (ph > 3'd4) ? t[4][k] : t[ph][k];
  endfunction

  // Correlator phase for phase ph, bit k.
  function automatic logic [2:0] bit_ph(input logic [2:0] ph, input logic [2:0] k);
    logic [2:0] t [5][8];
    t[0] = '{3'd0, 3'd4, 3'd3, 3'd3, 3'd2, 3'd1, 3'd1, 3'd0};
    t[1] = '{3'd1, 3'd0, 3'd4, 3'd4, 3'd3, 3'd2, 3'd2, 3'd1};
    t[2] = '{3'd2, 3'd1, 3'd0, 3'd0, 3'd4, 3'd3, 3'd3, 3'd2};
    t[3] = '{3'd3, 3'd2, 3'd1, 3'd1, 3'd0, 3'd4, 3'd4, 3'd3};
    t[4] = '{3'd4, 3'd3, 3'd2, 3'd2, 3'd1, 3'd0, 3'd0, 3'd4};
    return (ph > 3'd4) ? t[4][k] : t[ph][k];
  endfunction
endpackage
`default_nettype wire

FILE: sv/msps_ring.sv
// Sample ring memory: one write port, one registered read port.
`default_nettype none
module msps_ring import msps_pkg::*; #(
  parameter int RING_DEPTH = RingDepthDef
) (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [$clog2(RING_DEPTH)-1:0] wr_addr,
  input  wire logic [15:0]                   wr_data,
  input  wire logic [$clog2(RING_DEPTH)-1:0] rd_addr,
  output logic      [15:0]                   rd_data
);
  logic [15:0] mem [RING_DEPTH];

  // Write on transfer, read every cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

FILE: sv/msps_scan.sv
// Scan front: window bookkeeping, skip count and preamble test.
`default_nettype none
module msps_scan import msps_pkg::*; #(
  parameter int RING_DEPTH = RingDepthDef
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  input  wire logic [15:0]                   sample,
  output logic                               busy,
  input  wire logic [9:0]                    threshold,
  output logic [$clog2(RING_DEPTH)-1:0]      wr_addr,
  output logic [$clog2(RING_DEPTH)-1:0]      rd_addr,
  input  wire logic [15:0]                   rd_data,
  input  wire logic                          rd_grant,
  output logic                               job_valid,
  output job_t                               job,
  input  wire logic                          job_ready,
  input  wire logic                          set_skip,
  input  wire logic [8:0]                    skip_val
);
  localparam int AW  = $clog2(RING_DEPTH);
  localparam int AW1 = AW + 1;
  typedef enum logic [1:0] {S_IDLE, S_READ, S_EVAL, S_JOB} state_t;

  state_t      state_r;
  logic [AW-1:0] wpos_r, base_r;
  logic [8:0]  fill_r, skip_r;
  logic [4:0]  k_r;
  logic [15:0] m_r [19];
  logic        rd_pend_r;
  logic [4:0]  rd_idx_r;

  logic [AW-1:0] base_nxt, wpos_nxt;
  logic [AW1-1:0] bsum, rsum;
  logic [19:0] noise;
  logic [19:0] pulse;
  logic [29:0] ref_v;
  logic        pre_ok, hit;

  // Window base after this sample is written, wrapped by compare and subtract
  assign bsum     = AW1'(wpos_r) + AW1'(RING_DEPTH - ScanWindow + 1);
  assign base_nxt = (bsum >= AW1'(RING_DEPTH)) ? AW'(bsum - AW1'(RING_DEPTH)) : AW'(bsum);
  assign wpos_nxt = (wpos_r == AW'(RING_DEPTH - 1)) ? '0 : wpos_r + AW'(1);
  assign rsum     = AW1'(base_r) + AW1'(k_r);
  assign wr_addr  = wpos_r;
  assign rd_addr  = (rsum >= AW1'(RING_DEPTH)) ? AW'(rsum - AW1'(RING_DEPTH)) : AW'(rsum);
  assign busy     = (state_r != S_IDLE);
  assign job_valid = (state_r == S_JOB);
  assign job.base  = 10'(base_r);

  assign pre_ok = m_r[1] > m_r[7] && m_r[4] > m_r[7] && m_r[11] > m_r[18] &&
                  m_r[14] > m_r[18];
  assign noise = 20'(m_r[6]) + 20'(m_r[7]) + 20'(m_r[8]) + 20'(m_r[17]) + 20'(m_r[18]);
  assign pulse = 20'(m_r[0]) + 20'(m_r[1]) + 20'(m_r[3]) + 20'(m_r[4]) +
                 20'(m_r[10]) + 20'(m_r[11]) + 20'(m_r[13]) + 20'(m_r[14]);
  assign ref_v = (30'(noise) * 30'(threshold)) >> 5;
  // mag >= ref  <=>  pulse >= noise + ref
  assign hit   = pre_ok && (31'(pulse) >= 31'(noise) + 31'(ref_v));

  // Sequence: take sample, read 19 window samples, test, post job on a hit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wpos_r <= '0; fill_r <= '0; skip_r <= '0; base_r <= '0;
      k_r <= '0; rd_pend_r <= 1'b0; rd_idx_r <= '0;
    end else begin
      rd_pend_r <= (state_r == S_READ) && rd_grant;
      if (rd_pend_r) m_r[rd_idx_r] <= rd_data;
      if (set_skip) skip_r <= skip_val;
      case (state_r)
        S_IDLE: begin
          if (push) begin
            wpos_r <= wpos_nxt;
            base_r <= base_nxt;
            if (fill_r < 9'(ScanWindow)) fill_r <= fill_r + 9'd1;
            if (fill_r + 9'd1 >= 9'(ScanWindow)) begin
              if (skip_r != '0) skip_r <= skip_r - 9'd1;
              else begin
                k_r <= '0;
                state_r <= S_READ;
              end
            end
          end
        end
        S_READ: begin
          if (rd_grant) begin
            rd_idx_r  <= k_r;
            if (k_r == 5'd18) state_r <= S_EVAL;
            else k_r <= k_r + 5'd1;
          end
        end
        S_EVAL: begin
          if (!rd_pend_r) state_r <= hit ? S_JOB : S_IDLE;
        end
        S_JOB: begin
          if (job_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: sv/msps_slice.sv
// Slicer back end: correlates bits per byte and queues result bytes.
`default_nettype none
module msps_slice import msps_pkg::*; #(
  parameter int RING_DEPTH = RingDepthDef
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     job_valid,
  input  job_t                          job,
  output logic                          job_ready,
  input  wire logic [4:0]               trial,
  output logic [$clog2(RING_DEPTH)-1:0] rd_addr,
  output logic                          rd_req,
  input  wire logic [15:0]              rd_data,
  output logic                          set_skip,
  output logic [8:0]                    skip_val,
  output logic                          res_valid,
  output res_t                          res,
  input  wire logic                     res_pop
);
  localparam int AW = $clog2(RING_DEPTH);
  typedef enum logic [2:0] {T_IDLE, T_RD, T_COR, T_BYTE, T_PUSH} state_t;

  state_t      state_r;
  logic [9:0]  base_r;
  logic [2:0]  ph_r;
  logic [8:0]  pos_r;     // byte start offset in window
  logic [3:0]  bidx_r;
  logic [2:0]  bit_r;
  logic [1:0]  tap_r;
  logic        pend_r;
  logic [1:0]  ptap_r;
  logic [15:0] tap_v_r [4];
  logic [7:0]  byte_r;
  logic        long_r;
  logic [3:0]  nby_r;
  res_t        q_r;
  logic        q_full_r;

  logic [4:0]  tp;
  logic [1:0]  tp_q;
  logic [2:0]  tp_r;
  logic [2:0]  cph;
  logic [9:0]  off;
  logic [10:0] asum;
  logic signed [21:0] a, b, c, d;
  logic signed [31:0] cor;
  logic [7:0]  nb;
  logic [4:0]  df;

  assign tp  = (trial > 5'(MaxTrial)) ? 5'(MaxTrial) : trial;
  // Split trial phase into sample offset and sub-sample phase
  always_comb begin
    if (tp >= 5'd15) tp_q = 2'd3;
    else if (tp >= 5'd10) tp_q = 2'd2;
    else if (tp >= 5'd5) tp_q = 2'd1;
    else tp_q = 2'd0;
  end
  assign tp_r = 3'(tp - 5'(tp_q) * 5'd5);

  assign cph = bit_ph(ph_r, bit_r);
  assign off = 10'(pos_r) + 10'(bit_off(ph_r, bit_r)) + 10'(tap_r);
  assign asum = 11'(base_r) + 11'(off);
  assign rd_addr = (asum >= 11'(RING_DEPTH)) ? AW'(asum - 11'(RING_DEPTH)) : AW'(asum);
  assign rd_req  = (state_r == T_RD);
  assign job_ready = (state_r == T_IDLE);

  assign a = 22'(tap_v_r[0]); assign b = 22'(tap_v_r[1]);
  assign c = 22'(tap_v_r[2]); assign d = 22'(tap_v_r[3]);
  // Phase correlator
  always_comb begin
    case (cph)
      3'd0: cor = 10*a - b - 9*c;
      3'd1: cor = 8*a + 3*b - 10*c - d;
      3'd2: cor = 6*a + 7*b - 10*c - 3*d;
      3'd3: cor = 4*a + 10*b - 9*c - 5*d;
      default: cor = 2*a + 10*b - 5*c - 7*d;
    endcase
  end
  assign nb = {byte_r[6:0], cor > 0};
  assign df = byte_r[7:3];

  assign res_valid = q_full_r;
  assign res       = q_r;
  assign set_skip  = (state_r == T_BYTE) && (bidx_r == 4'd0) &&
                     (LongDfSet[df] || ShortDfSet[df]);
  assign skip_val  = LongDfSet[df] ? SkipLong : SkipShort;

  // Slice sequencer: four taps per bit, eight bits per byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE; q_full_r <= 1'b0; pend_r <= 1'b0;
    end else begin
      pend_r <= (state_r == T_RD);
      if (pend_r) tap_v_r[ptap_r] <= rd_data;
      if (res_pop && state_r != T_PUSH) q_full_r <= 1'b0;
      case (state_r)
        T_IDLE: begin
          if (job_valid) begin
            base_r <= job.base;
            ph_r   <= tp_r;
            pos_r  <= 9'(PreambleLen) + 9'(tp_q);
            bidx_r <= '0; bit_r <= '0; tap_r <= '0; byte_r <= '0;
            state_r <= T_RD;
          end
        end
        T_RD: begin
          ptap_r <= tap_r;
          tap_r  <= tap_r + 2'd1;
          if (tap_r == 2'd3) state_r <= T_COR;
        end
        T_COR: begin
          if (!pend_r) begin
            byte_r <= nb;
            bit_r  <= bit_r + 3'd1;
            state_r <= (bit_r == 3'd7) ? T_BYTE : T_RD;
          end
        end
        T_BYTE: begin
          if (bidx_r == 4'd0) begin
            long_r <= LongDfSet[df];
            nby_r  <= LongDfSet[df] ? 4'd14 : 4'd7;
            state_r <= (LongDfSet[df] || ShortDfSet[df]) ? T_PUSH : T_IDLE;
          end else state_r <= T_PUSH;
        end
        T_PUSH: begin
          if (!q_full_r || res_pop) begin
            q_r.data_byte    <= byte_r;
            q_r.byte_index   <= bidx_r;
            q_r.long_message <= long_r;
            q_r.last_byte    <= (bidx_r + 4'd1 == nby_r);
            q_full_r <= 1'b1;
            if (bidx_r + 4'd1 == nby_r) state_r <= T_IDLE;
            else begin
              bidx_r <= bidx_r + 4'd1;
              pos_r  <= pos_r + 9'(ByteSamples);
              byte_r <= '0;
              state_r <= T_RD;
            end
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: sv/mode_s_preamble_and_bit_slicer_top.sv
// Mode S preamble detector and bit slicer, top level.
// Input: push/full queue of 16-bit magnitude samples; each transfer writes
// the sample ring and, once 349 samples are held, tests a preamble at the
// oldest window sample, reading the window through the ring's one read port;
// a skipped sample, or one taken before the window is full, is only written.
// On a hit the slicer reads four ring samples per bit, eight bits per byte,
// through a long or a short message, while full stays high. Output:
// empty/pop queue, one byte per transfer, with byte_index, long_message and
// last_byte. A single result register parts the sides; a stalled receiver
// holds the slicer, which holds the input.
// Reset clears pointers, fill and skip counts and registers (threshold 58,
// trial phase 0); ring contents need no clearing. Config writes: cfg_we,
// cfg_index 0 threshold, 1 trial phase, others ignored.
`default_nettype none
module mode_s_preamble_and_bit_slicer_top import msps_pkg::*; #(
  parameter int RING_DEPTH = RingDepthDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [15:0] in_sample,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [7:0]       out_data_byte,
  output logic [3:0]       out_byte_index,
  output logic             out_long_message,
  output logic             out_last_byte,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);
  localparam int AW = $clog2(RING_DEPTH);
  logic [9:0] thr_r;
  logic [4:0] trial_r;
  logic busy, job_valid, job_ready, set_skip, res_valid, s_rd;
  job_t job;
  res_t res;
  logic [8:0] skip_val;
  logic [AW-1:0] wr_addr, srd, trd, rd_addr;
  logic [15:0] rd_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= ThreshReset; trial_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CfgThreshold) thr_r <= cfg_data;
      if (cfg_index == CfgTrial) trial_r <= cfg_data[4:0];
    end
  end

  // Hold input while the scan tests or the slicer works on a message
  assign in_full = busy || !job_ready;
  // Slicer owns the read port while it requests reads
  assign rd_addr = s_rd ? trd : srd;

  msps_ring #(.RING_DEPTH(RING_DEPTH)) u_ring (
    .clk(clk), .wr_en(in_push && !in_full), .wr_addr(wr_addr), .wr_data(in_sample),
    .rd_addr(rd_addr), .rd_data(rd_data));

  msps_scan #(.RING_DEPTH(RING_DEPTH)) u_scan (
    .clk(clk), .rst_n(rst_n), .push(in_push && !in_full), .sample(in_sample),
    .busy(busy), .threshold(thr_r), .wr_addr(wr_addr), .rd_addr(srd),
    .rd_data(rd_data), .rd_grant(!s_rd), .job_valid(job_valid), .job(job),
    .job_ready(job_ready), .set_skip(set_skip), .skip_val(skip_val));

  msps_slice #(.RING_DEPTH(RING_DEPTH)) u_slice (
    .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job(job),
    .job_ready(job_ready), .trial(trial_r), .rd_addr(trd), .rd_req(s_rd),
    .rd_data(rd_data), .set_skip(set_skip), .skip_val(skip_val),
    .res_valid(res_valid), .res(res), .res_pop(out_pop));

  assign out_empty        = !res_valid;
  assign out_data_byte    = res.data_byte;
  assign out_byte_index   = res.byte_index;
  assign out_long_message = res.long_message;
  assign out_last_byte    = res.last_byte;

  // A job is only posted while the front is busy
  a_job_busy: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid |-> busy) else $error("job without busy front");
  // Short messages never index past byte 6
  a_short_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_long_message) |-> out_byte_index <= 4'd6)
    else $error("short message index overflow");
  // Result held while not popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data_byte)))
    else $error("result dropped");
endmodule
`default_nettype wire
